### rtl/arqt_pkg.sv
package arqt_pkg;

	// Default table depth and the most results one tick may produce.
	localparam int SLOTS_DEF   = 32;
	localparam int MAX_RESULTS = 32;

	// Register reset values.
	localparam logic [15:0] TIMEOUT_RST = 16'd300;
	localparam logic [3:0]  RETRY_RST   = 4'd5;
	localparam logic [9:0]  SCAN_RST    = 10'd50;

	typedef enum logic [1:0] {
		REG_TIMEOUT = 2'd0,
		REG_RETRY   = 2'd1,
		REG_SCAN    = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		ACT_SEND = 2'd0,
		ACT_ACK  = 2'd1,
		ACT_NACK = 2'd2,
		ACT_TICK = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		K_TRACKED   = 4'd0,
		K_UNTRACKED = 4'd1,
		K_FULL      = 4'd2,
		K_ACKED     = 4'd3,
		K_ACK_MISS  = 4'd4,
		K_NACKED    = 4'd5,
		K_NACK_MISS = 4'd6,
		K_RETX      = 4'd7,
		K_GAVE_UP   = 4'd8,
		K_IDLE      = 4'd9
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [31:0] seq;
		logic [15:0] handle;
		logic [31:0] sent;
		logic [3:0]  retries;
	} entry_t;

	typedef struct packed {
		kind_t       kind;
		logic [4:0]  slot;
		logic [31:0] seq;
		logic [15:0] handle;
		logic [3:0]  attempt;
		logic [31:0] latency;
		logic        last;
	} result_t;

endpackage

### rtl/ack_retransmit_tracker.sv
// An item is taken while the tracker is idle, then walks the table at one slot per cycle, behind a
// registered memory read and only while the output register can take a result; a send, ack or nack
// ends at the first hit. A tick keeps the input closed for its whole walk and a final flush of the
// last result, and no new item is taken before the one in hand is done; the one read port
// of the slot memory and the shared age subtractor set this, and a full output register stalls
// the walk. Reset clears every busy bit, the millisecond clock and the registers to their defaults.
module ack_retransmit_tracker #(
	parameter int SLOTS = arqt_pkg::SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB-style configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [31:0] seq_num,
	input  logic [15:0] packet_handle,
	input  logic        reliable,
	// Result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  kind,
	output logic [4:0]  slot,
	output logic [31:0] event_seq,
	output logic [15:0] event_handle,
	output logic [3:0]  attempt,
	output logic [31:0] latency_ms,
	output logic        last
);

	// Index width for the slot memory and a counter wide enough to hold SLOTS itself.
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int NW = $clog2(arqt_pkg::MAX_RESULTS + 1);

	// Configuration registers.
	logic [15:0] timeout_q;
	logic [3:0]  retry_q;
	logic [9:0]  scan_q;

	// The item being worked on.
	arqt_pkg::state_t  state_q, state_d;
	arqt_pkg::action_t act_q;
	logic [31:0]       seq_q;
	logic [15:0]       handle_q;
	logic              rel_q;

	logic [31:0]       clock_q;
	logic [SLOTS-1:0]  busy_q;

	// Slot contents live in a memory with one write port and one registered read port.
	arqt_pkg::entry_t  mem [SLOTS];
	arqt_pkg::entry_t  rd_s1;
	logic [IW-1:0]     rd_idx_s1;
	logic              pend_s1;
	logic [CW-1:0]     issue_q;
	logic [NW-1:0]     nres_q;

	// A tick cannot tell whether a result is its final one until the walk is over, so each tick result
	// waits in a hold register until a newer one or the final flush moves it to the output register.
	logic              hold_valid_q;
	arqt_pkg::result_t hold_q;
	logic              out_valid_q;
	arqt_pkg::result_t out_q;

	logic              in_acc;
	logic              adv;
	logic [31:0]       age_c;
	logic              match_c;
	logic              last_slot_c;
	logic              issue_c;
	logic              done_c;
	logic              flush_c;
	logic              we_c;
	arqt_pkg::entry_t  wdata_c;
	logic              set_busy_c;
	logic              clr_busy_c;
	logic              emit_c;
	logic              to_hold_c;
	arqt_pkg::result_t res_c;
	logic              out_load_c;
	arqt_pkg::result_t out_d_c;

	assign pready    = 1'b1;
	assign in_ready  = (state_q == arqt_pkg::ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	// The walk only moves when the output register can take a result this cycle.
	assign adv       = !out_valid_q || out_ready;

	// ------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= arqt_pkg::TIMEOUT_RST;
			retry_q   <= arqt_pkg::RETRY_RST;
			scan_q    <= arqt_pkg::SCAN_RST;
		end else if (psel && penable && pwrite) begin
			unique case (arqt_pkg::reg_idx_t'(paddr[3:2]))
				arqt_pkg::REG_TIMEOUT: timeout_q <= pwdata[15:0];
				arqt_pkg::REG_RETRY:   retry_q   <= pwdata[3:0];
				arqt_pkg::REG_SCAN:    scan_q    <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (arqt_pkg::reg_idx_t'(paddr[3:2]))
			arqt_pkg::REG_TIMEOUT: prdata = {16'd0, timeout_q};
			arqt_pkg::REG_RETRY:   prdata = {28'd0, retry_q};
			arqt_pkg::REG_SCAN:    prdata = {22'd0, scan_q};
			default:               prdata = 32'd0;
		endcase
	end

	// ------------------------------------------------------------------
	// Evaluation of the slot whose contents have just been read. The one
	// subtractor gives both the overdue age and the ack latency.
	// ------------------------------------------------------------------
	assign age_c       = clock_q - rd_s1.sent;
	assign match_c     = busy_q[rd_idx_s1] && (rd_s1.seq == seq_q);
	assign last_slot_c = (rd_idx_s1 == IW'(SLOTS - 1));

	always_comb begin
		done_c     = 1'b0;
		flush_c    = 1'b0;
		we_c       = 1'b0;
		wdata_c    = rd_s1;
		set_busy_c = 1'b0;
		clr_busy_c = 1'b0;
		emit_c     = 1'b0;
		to_hold_c  = 1'b0;
		res_c      = '0;
		res_c.kind = arqt_pkg::K_IDLE;

		if (state_q == arqt_pkg::ST_WALK && adv) begin
			if (act_q == arqt_pkg::ACT_SEND && !rel_q) begin
				emit_c       = 1'b1;
				done_c       = 1'b1;
				res_c.kind   = arqt_pkg::K_UNTRACKED;
				res_c.seq    = seq_q;
				res_c.handle = handle_q;
				res_c.last   = 1'b1;
			end else if (pend_s1) begin
				unique case (act_q)
					arqt_pkg::ACT_SEND: begin
						if (!busy_q[rd_idx_s1]) begin
							we_c          = 1'b1;
							wdata_c       = '{seq: seq_q, handle: handle_q, sent: clock_q,
								retries: 4'd0};
							set_busy_c    = 1'b1;
							emit_c        = 1'b1;
							done_c        = 1'b1;
							res_c.kind    = arqt_pkg::K_TRACKED;
							res_c.slot    = 5'(rd_idx_s1);
							res_c.seq     = seq_q;
							res_c.handle  = handle_q;
							res_c.last    = 1'b1;
						end else if (last_slot_c) begin
							emit_c        = 1'b1;
							done_c        = 1'b1;
							res_c.kind    = arqt_pkg::K_FULL;
							res_c.seq     = seq_q;
							res_c.handle  = handle_q;
							res_c.last    = 1'b1;
						end
					end
					arqt_pkg::ACT_ACK: begin
						if (match_c) begin
							clr_busy_c    = 1'b1;
							emit_c        = 1'b1;
							done_c        = 1'b1;
							res_c.kind    = arqt_pkg::K_ACKED;
							res_c.slot    = 5'(rd_idx_s1);
							res_c.seq     = rd_s1.seq;
							res_c.handle  = rd_s1.handle;
							res_c.attempt = rd_s1.retries;
							res_c.latency = age_c;
							res_c.last    = 1'b1;
						end else if (last_slot_c) begin
							emit_c        = 1'b1;
							done_c        = 1'b1;
							res_c.kind    = arqt_pkg::K_ACK_MISS;
							res_c.seq     = seq_q;
							res_c.last    = 1'b1;
						end
					end
					arqt_pkg::ACT_NACK: begin
						if (match_c) begin
							we_c          = 1'b1;
							wdata_c.sent  = 32'd0;
							emit_c        = 1'b1;
							done_c        = 1'b1;
							res_c.kind    = arqt_pkg::K_NACKED;
							res_c.slot    = 5'(rd_idx_s1);
							res_c.seq     = rd_s1.seq;
							res_c.handle  = rd_s1.handle;
							res_c.attempt = rd_s1.retries;
							res_c.last    = 1'b1;
						end else if (last_slot_c) begin
							emit_c        = 1'b1;
							done_c        = 1'b1;
							res_c.kind    = arqt_pkg::K_NACK_MISS;
							res_c.seq     = seq_q;
							res_c.last    = 1'b1;
						end
					end
					arqt_pkg::ACT_TICK: begin
						if (busy_q[rd_idx_s1] && age_c >= {16'd0, timeout_q}) begin
							to_hold_c    = 1'b1;
							res_c.slot   = 5'(rd_idx_s1);
							res_c.seq    = rd_s1.seq;
							res_c.handle = rd_s1.handle;
							if (rd_s1.retries >= retry_q) begin
								clr_busy_c    = 1'b1;
								res_c.kind    = arqt_pkg::K_GAVE_UP;
								res_c.attempt = rd_s1.retries;
							end else begin
								we_c            = 1'b1;
								wdata_c.retries = rd_s1.retries + 4'd1;
								wdata_c.sent    = clock_q;
								res_c.kind      = arqt_pkg::K_RETX;
								res_c.attempt   = rd_s1.retries + 4'd1;
							end
							if (last_slot_c || nres_q == NW'(arqt_pkg::MAX_RESULTS - 1)) begin
								flush_c = 1'b1;
							end
						end else if (last_slot_c) begin
							flush_c = 1'b1;
						end
					end
					default: ;
				endcase
			end
		end

		issue_c = (state_q == arqt_pkg::ST_WALK) && adv && !done_c && !flush_c &&
			(issue_q != CW'(SLOTS));
	end

	// Output register loading: direct results, a held tick result displaced by a newer one,
	// or the final flush of a tick (the held result marked last, or scan idle if none).
	always_comb begin
		out_load_c = 1'b0;
		out_d_c    = res_c;
		if (emit_c) begin
			out_load_c = 1'b1;
		end else if (to_hold_c && hold_valid_q) begin
			out_load_c = 1'b1;
			out_d_c    = hold_q;
		end else if (state_q == arqt_pkg::ST_FLUSH && adv) begin
			out_load_c = 1'b1;
			if (hold_valid_q) begin
				out_d_c      = hold_q;
				out_d_c.last = 1'b1;
			end else begin
				out_d_c      = '0;
				out_d_c.kind = arqt_pkg::K_IDLE;
				out_d_c.last = 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			arqt_pkg::ST_IDLE: begin
				if (in_acc) begin
					state_d = arqt_pkg::ST_WALK;
				end
			end
			arqt_pkg::ST_WALK: begin
				if (done_c) begin
					state_d = arqt_pkg::ST_IDLE;
				end else if (flush_c) begin
					state_d = arqt_pkg::ST_FLUSH;
				end
			end
			arqt_pkg::ST_FLUSH: begin
				if (adv) begin
					state_d = arqt_pkg::ST_IDLE;
				end
			end
			default: state_d = arqt_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= arqt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Item capture; the clock advances as a tick is taken, so the walk sees the new time.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q    <= arqt_pkg::action_t'(action);
			seq_q    <= seq_num;
			handle_q <= packet_handle;
			rel_q    <= reliable;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= 32'd0;
		end else if (in_acc && arqt_pkg::action_t'(action) == arqt_pkg::ACT_TICK) begin
			clock_q <= clock_q + {22'd0, scan_q};
		end
	end

	// Walk control: read issue counter, read-pending flag and tick result count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= '0;
			pend_s1 <= 1'b0;
			nres_q  <= '0;
		end else if (in_acc) begin
			issue_q <= '0;
			pend_s1 <= 1'b0;
			nres_q  <= '0;
		end else if (state_q == arqt_pkg::ST_WALK && adv) begin
			pend_s1 <= issue_c;
			if (issue_c) begin
				issue_q <= issue_q + CW'(1);
			end
			if (to_hold_c) begin
				nres_q <= nres_q + NW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else if (set_busy_c) begin
			busy_q[rd_idx_s1] <= 1'b1;
		end else if (clr_busy_c) begin
			busy_q[rd_idx_s1] <= 1'b0;
		end
	end

	// Slot memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we_c) begin
			mem[rd_idx_s1] <= wdata_c;
		end
		if (issue_c) begin
			rd_s1     <= mem[issue_q[IW-1:0]];
			rd_idx_s1 <= issue_q[IW-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Hold and output registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (to_hold_c) begin
			hold_valid_q <= 1'b1;
		end else if (state_q == arqt_pkg::ST_FLUSH && adv) begin
			hold_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (to_hold_c) begin
			hold_q <= res_c;
		end
		if (out_load_c) begin
			out_q <= out_d_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load_c) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = out_q.kind;
	assign slot         = out_q.slot;
	assign event_seq    = out_q.seq;
	assign event_handle = out_q.handle;
	assign attempt      = out_q.attempt;
	assign latency_ms   = out_q.latency;
	assign last         = out_q.last;

endmodule
